FILE: rtl/ulwcc_pkg.sv
// Shared types and byte constants for the UTF-8 line, word and character counter.
package ulwcc_pkg;

    // Width of the count fields on the result port
    localparam int unsigned OUT_WIDTH = 32;

    // Byte codes
    localparam logic [7:0] BYTE_TAB      = 8'h09;
    localparam logic [7:0] BYTE_NEWLINE  = 8'h0A;
    localparam logic [7:0] BYTE_CR       = 8'h0D;
    localparam logic [7:0] BYTE_SPACE    = 8'h20;
    localparam logic [7:0] BYTE_DEL      = 8'h7F;
    localparam logic [7:0] BYTE_CONT_LO  = 8'h80;
    localparam logic [7:0] BYTE_CONT_HI  = 8'hBF;
    localparam logic [7:0] BYTE_LEAD2_LO = 8'hC0;
    localparam logic [7:0] BYTE_OVERLONG = 8'hC1;
    localparam logic [7:0] BYTE_LEAD2_HI = 8'hDF;
    localparam logic [7:0] BYTE_LEAD3_LO = 8'hE0;
    localparam logic [7:0] BYTE_LEAD3_HI = 8'hEF;
    localparam logic [7:0] BYTE_LEAD4_LO = 8'hF0;
    localparam logic [7:0] BYTE_LEAD4_HI = 8'hF4;
    localparam logic [7:0] BYTE_BAD_LO   = 8'hF5;

    // Continuation bytes still expected after a lead byte
    localparam logic [1:0] CONT_NONE = 2'd0;
    localparam logic [1:0] CONT_ONE  = 2'd1;
    localparam logic [1:0] CONT_TWO  = 2'd2;
    localparam logic [1:0] CONT_THREE = 2'd3;

    // One result item
    typedef struct packed {
        logic [OUT_WIDTH-1:0] lines;
        logic [OUT_WIDTH-1:0] words;
        logic [OUT_WIDTH-1:0] chars;
        logic                 bad;
        logic                 final_res;
    } t_result;

endpackage

FILE: rtl/utf8_line_word_char_counter.sv
// Top level of the UTF-8 aware line, word and character counter.
//
// Takes one text byte per transfer and returns one result per byte holding the running
// newline, word and character counts, a flag for a byte that breaks UTF-8 rules, and a
// final flag on the byte marked end-of-stream, whose counts are the stream totals; the
// counters then clear for the next stream. Throughput is one byte per clock while o_stall
// is low: the whole update (classification plus one saturating COUNT_WIDTH-bit increment
// per counter) is done in the cycle of the input transfer and captured at the accepting
// edge in the output register, or in the skid slot while the output register is held.
// A two-deep output stage (output register plus skid) keeps o_stall a pure register:
// while the result side stalls, one more transfer is taken into the skid slot, then
// o_stall stays high until the output register moves.
// utf8_mode is written through i_cfg_wr_en/i_cfg_wr_data by the user, only while the
// block is idle; the block does not enforce this. 0 counts bytes, 1 counts UTF-8
// characters. Counters saturate at all ones; the result ports carry their low 32 bits.
module utf8_line_word_char_counter #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_wr_en,
    input  logic                          i_cfg_wr_data,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_end_of_stream,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ulwcc_pkg::OUT_WIDTH-1:0] o_lines_so_far,
    output logic [ulwcc_pkg::OUT_WIDTH-1:0] o_words_so_far,
    output logic [ulwcc_pkg::OUT_WIDTH-1:0] o_chars_so_far,
    output logic                          o_bad_byte,
    output logic                          o_final_result
);

    // Mode register
    logic r_utf8_mode;

    // Stream state
    logic                   r_inside_word,   n_inside_word;
    logic                   r_inside_seq,    n_inside_seq;
    logic [1:0]             r_cont_left,     n_cont_left;
    logic [COUNT_WIDTH-1:0] r_line_total,    n_line_total;
    logic [COUNT_WIDTH-1:0] r_word_total,    n_word_total;
    logic [COUNT_WIDTH-1:0] r_char_total,    n_char_total;

    // Output register and skid slot
    logic                 r_out_valid;
    logic                 r_skid_valid;
    ulwcc_pkg::t_result   r_out;
    ulwcc_pkg::t_result   r_skid;
    ulwcc_pkg::t_result   n_result;

    logic in_xfer;
    logic out_xfer;

    // Classification and update terms
    logic                   is_space;
    logic                   starts_word;
    logic                   is_cont;
    logic                   is_forbidden;
    logic                   word_after;
    logic                   word_inc;
    logic                   char_inc;
    logic                   bad;
    logic [1:0]             cont_dec;
    logic [COUNT_WIDTH-1:0] line_upd;
    logic [COUNT_WIDTH-1:0] word_upd;
    logic [COUNT_WIDTH-1:0] char_upd;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (&v) ? v : v + COUNT_WIDTH'(1);
    endfunction

    assign o_stall  = r_skid_valid;
    assign in_xfer  = i_valid && !r_skid_valid;
    assign out_xfer = r_out_valid && !i_stall;

    always_comb begin
        is_space     = i_data_byte inside {[ulwcc_pkg::BYTE_TAB:ulwcc_pkg::BYTE_CR],
                                           ulwcc_pkg::BYTE_SPACE};
        starts_word  = (i_data_byte > ulwcc_pkg::BYTE_SPACE) &&
                       (i_data_byte != ulwcc_pkg::BYTE_DEL);
        is_cont      = i_data_byte inside {[ulwcc_pkg::BYTE_CONT_LO:ulwcc_pkg::BYTE_CONT_HI]};
        is_forbidden = i_data_byte inside {ulwcc_pkg::BYTE_LEAD2_LO, ulwcc_pkg::BYTE_OVERLONG,
                                           [ulwcc_pkg::BYTE_BAD_LO:8'hFF]};

        // A space closes an open word; the end-of-stream byte closes whatever is open.
        // Both cannot fire on one byte since a space never reopens a word.
        word_after = is_space ? 1'b0 : (r_inside_word || starts_word);
        word_inc   = (r_inside_word && is_space) || (i_end_of_stream && word_after);

        cont_dec = r_cont_left - 2'd1;
        char_inc = 1'b0;
        bad      = 1'b0;
        n_inside_seq = r_inside_seq;
        n_cont_left  = r_cont_left;

        if (r_utf8_mode) begin
            if (is_cont) begin
                if (r_inside_seq) begin
                    n_cont_left = cont_dec;
                    if (cont_dec == ulwcc_pkg::CONT_NONE) begin
                        n_inside_seq = 1'b0;
                        char_inc     = 1'b1;
                    end
                end else begin
                    bad = 1'b1;   // stray continuation
                end
            end else begin
                // interrupting byte drops the partial sequence
                bad          = r_inside_seq;
                n_inside_seq = 1'b0;
                n_cont_left  = ulwcc_pkg::CONT_NONE;
                if (!i_data_byte[7]) begin
                    char_inc = 1'b1;
                end else if (is_forbidden) begin
                    bad = 1'b1;
                end else if (i_data_byte <= ulwcc_pkg::BYTE_LEAD2_HI) begin
                    n_inside_seq = 1'b1;
                    n_cont_left  = ulwcc_pkg::CONT_ONE;
                end else if (i_data_byte <= ulwcc_pkg::BYTE_LEAD3_HI) begin
                    n_inside_seq = 1'b1;
                    n_cont_left  = ulwcc_pkg::CONT_TWO;
                end else begin
                    n_inside_seq = 1'b1;
                    n_cont_left  = ulwcc_pkg::CONT_THREE;
                end
            end
        end else begin
            n_inside_seq = 1'b0;
            n_cont_left  = ulwcc_pkg::CONT_NONE;
            char_inc     = 1'b1;
        end

        line_upd = (i_data_byte == ulwcc_pkg::BYTE_NEWLINE) ? sat_inc(r_line_total)
                                                            : r_line_total;
        word_upd = word_inc ? sat_inc(r_word_total) : r_word_total;
        char_upd = char_inc ? sat_inc(r_char_total) : r_char_total;

        n_result.lines     = ulwcc_pkg::OUT_WIDTH'(line_upd);
        n_result.words     = ulwcc_pkg::OUT_WIDTH'(word_upd);
        n_result.chars     = ulwcc_pkg::OUT_WIDTH'(char_upd);
        n_result.bad       = bad;
        n_result.final_res = i_end_of_stream;

        // End of stream clears everything for the next stream
        if (i_end_of_stream) begin
            n_inside_word = 1'b0;
            n_inside_seq  = 1'b0;
            n_cont_left   = ulwcc_pkg::CONT_NONE;
            n_line_total  = '0;
            n_word_total  = '0;
            n_char_total  = '0;
        end else begin
            n_inside_word = word_after;
            n_line_total  = line_upd;
            n_word_total  = word_upd;
            n_char_total  = char_upd;
        end
    end

    // Mode and stream state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_utf8_mode   <= 1'b0;
            r_inside_word <= 1'b0;
            r_inside_seq  <= 1'b0;
            r_cont_left   <= ulwcc_pkg::CONT_NONE;
            r_line_total  <= '0;
            r_word_total  <= '0;
            r_char_total  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_utf8_mode <= i_cfg_wr_data;
            end
            if (in_xfer) begin
                r_inside_word <= n_inside_word;
                r_inside_seq  <= n_inside_seq;
                r_cont_left   <= n_cont_left;
                r_line_total  <= n_line_total;
                r_word_total  <= n_word_total;
                r_char_total  <= n_char_total;
            end
        end
    end

    // Output register with skid slot; skid fills only while the output is held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_xfer || !r_out_valid) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_xfer;
                end
            end else if (in_xfer) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_xfer || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : n_result;
        end else if (in_xfer) begin
            r_skid <= n_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_lines_so_far = r_out.lines;
    assign o_words_so_far = r_out.words;
    assign o_chars_so_far = r_out.chars;
    assign o_bad_byte     = r_out.bad;
    assign o_final_result = r_out.final_res;

endmodule

FILE: tb/sv/utf8_line_word_char_counter_tb.sv
// Self-checking testbench for the UTF-8 line, word and character counter.
`timescale 1ns / 100ps

module utf8_line_word_char_counter_tb;

    // Counter width is kept narrower than the result ports, so the widening to
    // the port width is exercised.
    localparam int unsigned CNT_W      = 16;
    localparam logic [63:0] CNT_MAX    = (64'd1 << CNT_W) - 64'd1;
    localparam int          CLK_PERIOD = 10;
    localparam int          RST_CYCLES = 12;
    // Result passes through the output register, or through the skid slot first.
    localparam int          SETTLE     = 4;
    localparam int          TAIL       = 10;
    localparam int          LIMIT      = 1_000_000;
    localparam int          PHASE_LEN  = 325;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte     = 8'h00;
    logic        in_eos      = 1'b0;
    logic        res_valid;
    logic        res_stall   = 1'b0;
    logic [ulwcc_pkg::OUT_WIDTH-1:0] res_lines;
    logic [ulwcc_pkg::OUT_WIDTH-1:0] res_words;
    logic [ulwcc_pkg::OUT_WIDTH-1:0] res_chars;
    logic        res_bad;
    logic        res_final;

    // Idle and stall rates in percent, changed per phase.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    int unsigned mismatches = 0;
    int unsigned cycles     = 0;

    // Running counts the block should report, oldest first.
    ulwcc_pkg::t_result count_queue[$];

    // Predictor state: mirrors the block's stream state and its one register.
    logic        utf8_on   = 1'b0;
    logic        in_word   = 1'b0;
    logic        in_seq    = 1'b0;
    logic [1:0]  cont_left = ulwcc_pkg::CONT_NONE;
    logic [63:0] line_cnt  = '0;
    logic [63:0] word_cnt  = '0;
    logic [63:0] char_cnt  = '0;

    utf8_line_word_char_counter #(
        .COUNT_WIDTH(CNT_W)
    ) u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_valid        (in_valid),
        .o_stall        (in_stall),
        .i_data_byte    (in_byte),
        .i_end_of_stream(in_eos),
        .o_valid        (res_valid),
        .i_stall        (res_stall),
        .o_lines_so_far (res_lines),
        .o_words_so_far (res_words),
        .o_chars_so_far (res_chars),
        .o_bad_byte     (res_bad),
        .o_final_result (res_final)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [63:0] bump(input logic [63:0] v);
        return (v >= CNT_MAX) ? CNT_MAX : v + 64'd1;
    endfunction

    // Updates the stream state for one byte and returns the counts the block
    // must report for it. Word tracking runs in both modes; character
    // counting and the malformed-byte flag depend on utf8_on.
    function automatic ulwcc_pkg::t_result tally_byte(input logic [7:0] b, input logic eos);
        ulwcc_pkg::t_result r;
        logic    white;
        logic    bad;
        white = (b == ulwcc_pkg::BYTE_SPACE) ||
                (b >= ulwcc_pkg::BYTE_TAB && b <= ulwcc_pkg::BYTE_CR);
        bad   = 1'b0;

        if (b == ulwcc_pkg::BYTE_NEWLINE)
            line_cnt = bump(line_cnt);
        if (in_word && white) begin
            in_word  = 1'b0;
            word_cnt = bump(word_cnt);
        end
        // 0x80-0xFF start a word too
        if (!in_word && b > ulwcc_pkg::BYTE_SPACE && b != ulwcc_pkg::BYTE_DEL)
            in_word = 1'b1;

        if (utf8_on) begin
            if (b >= ulwcc_pkg::BYTE_CONT_LO && b <= ulwcc_pkg::BYTE_CONT_HI) begin
                if (in_seq) begin
                    cont_left = cont_left - 2'd1;
                    if (cont_left == ulwcc_pkg::CONT_NONE) begin
                        in_seq   = 1'b0;
                        char_cnt = bump(char_cnt);
                    end
                end else begin
                    bad = 1'b1;                 // stray continuation
                end
            end else begin
                // anything else inside a sequence drops it, then counts afresh
                if (in_seq) begin
                    bad       = 1'b1;
                    in_seq    = 1'b0;
                    cont_left = ulwcc_pkg::CONT_NONE;
                end
                if (b < ulwcc_pkg::BYTE_CONT_LO) begin
                    char_cnt = bump(char_cnt);
                end else if (b == ulwcc_pkg::BYTE_LEAD2_LO ||
                             b == ulwcc_pkg::BYTE_OVERLONG ||
                             b >= ulwcc_pkg::BYTE_BAD_LO) begin
                    bad = 1'b1;
                end else if (b < ulwcc_pkg::BYTE_LEAD3_LO) begin
                    in_seq    = 1'b1;
                    cont_left = ulwcc_pkg::CONT_ONE;
                end else if (b < ulwcc_pkg::BYTE_LEAD4_LO) begin
                    in_seq    = 1'b1;
                    cont_left = ulwcc_pkg::CONT_TWO;
                end else begin
                    in_seq    = 1'b1;
                    cont_left = ulwcc_pkg::CONT_THREE;
                end
            end
        end else begin
            in_seq    = 1'b0;
            cont_left = ulwcc_pkg::CONT_NONE;
            char_cnt  = bump(char_cnt);
        end

        // end of stream closes an open word
        if (eos && in_word) begin
            in_word  = 1'b0;
            word_cnt = bump(word_cnt);
        end

        r.lines     = line_cnt[ulwcc_pkg::OUT_WIDTH-1:0];
        r.words     = word_cnt[ulwcc_pkg::OUT_WIDTH-1:0];
        r.chars     = char_cnt[ulwcc_pkg::OUT_WIDTH-1:0];
        r.bad       = bad;
        r.final_res = eos;

        if (eos) begin
            in_word   = 1'b0;
            in_seq    = 1'b0;
            cont_left = ulwcc_pkg::CONT_NONE;
            line_cnt  = '0;
            word_cnt  = '0;
            char_cnt  = '0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stall, compare each transfer with the oldest
    // pending count set. Values are read right after the edge, so they
    // are the ones the block saw at that edge.
    // ------------------------------------------------------------------

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge clk) begin
        ulwcc_pkg::t_result want;
        if (rst_n && res_valid && !res_stall) begin
            if (count_queue.size() == 0) begin
                mismatches++;
                $display({"%0t: unexpected result: expected none, ",
                          "actual lines %0d words %0d chars %0d bad %0b final %0b"},
                         $time, res_lines, res_words, res_chars, res_bad, res_final);
            end else begin
                want = count_queue.pop_front();
                check_field("lines", want.lines, res_lines);
                check_field("words", want.words, res_words);
                check_field("chars", want.chars, res_chars);
                check_field("bad_byte", want.bad, res_bad);
                check_field("final_result", want.final_res, res_final);
            end
        end
        res_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // One byte transfer: optional idle gap, then hold until accepted.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        gap = 0;
        while ($urandom_range(99, 0) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_eos   <= eos;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        count_queue.push_back(tally_byte(b, eos));
    endtask

    // Stop sending and wait until every pending result has come back.
    task automatic drain;
        in_valid <= 1'b0;
        while (count_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Register write, only with the block idle.
    task automatic write_mode(input logic m);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        utf8_on      = m;
    endtask

    function automatic logic roll_eos;
        return ($urandom_range(39, 0) == 0);
    endfunction

    function automatic logic [7:0] rand_cont;
        return 8'($urandom_range(ulwcc_pkg::BYTE_CONT_HI, ulwcc_pkg::BYTE_CONT_LO));
    endfunction

    // Mostly well-formed text: ASCII, white space and complete multibyte
    // characters; some cut-off sequences and fully random bytes as noise.
    // Returns the number of bytes sent.
    task automatic send_random_char(output int unsigned sent);
        int unsigned pick;
        int unsigned conts;
        logic [7:0]  lead;
        pick = $urandom_range(99, 0);
        conts = 0;
        sent  = 1;
        if (pick < 35) begin
            send_byte(8'($urandom_range(8'h7E, 8'h21)), roll_eos());
        end else if (pick < 50) begin
            if ($urandom_range(1, 0))
                send_byte(ulwcc_pkg::BYTE_SPACE, roll_eos());
            else
                send_byte(8'($urandom_range(ulwcc_pkg::BYTE_CR, ulwcc_pkg::BYTE_TAB)),
                          roll_eos());
        end else if (pick < 80) begin
            if (pick < 60) begin
                lead  = 8'($urandom_range(ulwcc_pkg::BYTE_LEAD2_HI, 8'hC2));
                conts = 1;
            end else if (pick < 68) begin
                lead  = 8'($urandom_range(ulwcc_pkg::BYTE_LEAD3_HI, ulwcc_pkg::BYTE_LEAD3_LO));
                conts = 2;
            end else begin
                lead  = 8'($urandom_range(ulwcc_pkg::BYTE_LEAD4_HI, ulwcc_pkg::BYTE_LEAD4_LO));
                conts = 3;
            end
            // cut-off sequence: the next character interrupts it
            if (pick >= 74)
                conts = $urandom_range(conts - 1, 0);
            send_byte(lead, roll_eos());
            repeat (conts) begin
                send_byte(rand_cont(), roll_eos());
                sent++;
            end
        end else begin
            send_byte(8'($urandom_range(255, 0)), roll_eos());
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Byte mode: every byte is a character, nothing is flagged; extremes of
    // the byte range, DEL and controls that neither start nor end a word.
    task automatic test_byte_mode;
        write_mode(1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(ulwcc_pkg::BYTE_DEL, 1'b0);
        send_byte(ulwcc_pkg::BYTE_SPACE, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(ulwcc_pkg::BYTE_NEWLINE, 1'b0);
        send_byte(8'h21, 1'b1);         // open word closed by end of stream
    endtask

    // UTF-8 mode: 2, 3 and 4 byte characters, a stray continuation, a
    // forbidden lead, an interrupted sequence, a forbidden byte inside a
    // sequence and a sequence cut off by end of stream.
    task automatic test_utf8_directed;
        write_mode(1'b1);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(ulwcc_pkg::BYTE_CONT_HI, 1'b0);  // stray continuation
        send_byte(ulwcc_pkg::BYTE_LEAD2_LO, 1'b0); // overlong lead
        send_byte(8'hE2, 1'b0);
        send_byte(8'h41, 1'b0);         // ASCII interrupts, then counts
        send_byte(8'hC2, 1'b0);
        send_byte(8'hFF, 1'b0);         // forbidden byte drops the sequence
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);         // truncated at end of stream
    endtask

    // Random text in four pacing phases; the mode flips halfway through each
    // phase so that a change also lands in the middle of a stream.
    task automatic test_random_traffic;
        int unsigned idle_rates[4]  = '{0, 87, 0, 35};
        int unsigned stall_rates[4] = '{0, 0, 87, 35};
        logic        modes[4]       = '{1'b1, 1'b0, 1'b1, 1'b0};
        int unsigned total;
        int unsigned n;
        for (int p = 0; p < 4; p++) begin
            write_mode(modes[p]);
            send_idle_pct  = idle_rates[p];
            recv_stall_pct = stall_rates[p];
            total = 0;
            while (total < PHASE_LEN) begin
                if (total < PHASE_LEN / 2 && total + 4 >= PHASE_LEN / 2)
                    write_mode(~modes[p]);
                send_random_char(n);
                total += n;
            end
        end
    endtask

    initial begin
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_byte_mode();
        test_utf8_directed();
        test_random_traffic();

        drain();
        repeat (TAIL) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
